FILE: hdl/prpf_pkg.sv
// package: shared types and codes for the port rule packet filter
`timescale 1ns / 1ps
`default_nettype none
package prpf_pkg;

  localparam int CNT_W = 11;  // holds any rule count up to 2047

  localparam logic [1:0] CMD_CLASSIFY = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_DELETE   = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [1:0] HOOK_IN  = 2'd0;
  localparam logic [1:0] HOOK_OUT = 2'd1;
  localparam logic [1:0] HOOK_FWD = 2'd2;

  localparam logic [1:0] KIND_IN    = 2'd0;
  localparam logic [1:0] KIND_OUT   = 2'd1;
  localparam logic [1:0] KIND_FWD   = 2'd2;
  localparam logic [1:0] KIND_PROXY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [31:0] PROXY_RESET = 32'h8301_0101;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] port;
  } entry_t;

  typedef struct packed {
    logic             add;
    logic             del;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] idx;
    logic [1:0]       kind;
    logic [15:0]      port;
  } edit_t;

  typedef struct packed {
    logic             is_read;
    logic [1:0]       hook;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [CNT_W-1:0] idx;
  } query_t;

  typedef struct packed {
    logic        active;
    logic        found;
    logic [1:0]  kind;
    logic [15:0] port;
  } tok_t;

endpackage
`default_nettype wire

FILE: hdl/prpf_if.sv
// interfaces: input and result channels
`timescale 1ns / 1ps
`default_nettype none
interface prpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  hook_point;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] dst_address;
  logic [1:0]  rule_kind;
  logic [15:0] rule_port;
  logic [6:0]  rule_index;
  modport source (output valid, cmd, hook_point, src_port, dst_port, dst_address,
                  rule_kind, rule_port, rule_index, input ready);
  modport sink (input valid, cmd, hook_point, src_port, dst_port, dst_address,
                rule_kind, rule_port, rule_index, output ready);
endinterface

interface prpf_out_if;
  logic        valid;
  logic        ready;
  logic        drop;
  logic        rewritten;
  logic [31:0] out_dst_address;
  logic [15:0] out_dst_port;
  logic [1:0]  status;
  logic [7:0]  count_now;
  logic [1:0]  read_kind;
  logic [15:0] read_port;
  modport source (output valid, drop, rewritten, out_dst_address, out_dst_port, status,
                  count_now, read_kind, read_port, input ready);
  modport sink (input valid, drop, rewritten, out_dst_address, out_dst_port, status,
                count_now, read_kind, read_port, output ready);
endinterface
`default_nettype wire

FILE: hdl/prpf_cell.sv
// rule cell: one table entry plus one stage of the search chain
`timescale 1ns / 1ps
`default_nettype none
module prpf_cell
  import prpf_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire edit_t  edit,
  input  wire query_t query,
  input  wire entry_t nb_entry,
  output entry_t      entry,
  input  wire tok_t   tok_in,
  output tok_t        tok_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic hit;

  always_comb begin
    hit = 1'b0;
    if (entry.valid) begin
      if (query.is_read) begin
        hit = (query.idx == MY_IDX);
      end else begin
        case (query.hook)
          HOOK_IN:  hit = (entry.kind == KIND_IN || entry.kind == KIND_PROXY) &&
                          entry.port == query.sport;
          HOOK_OUT: hit = entry.kind == KIND_OUT && entry.port == query.dport;
          HOOK_FWD: hit = entry.kind == KIND_FWD && entry.port == query.sport;
          default:  hit = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid    <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      if (edit.add && edit.count == MY_IDX) begin
        entry <= '{valid: 1'b1, kind: edit.kind, port: edit.port};
      end else if (edit.del && MY_IDX >= edit.idx) begin
        // compaction: take the entry of the next cell
        entry <= nb_entry;
      end
      tok_out.active <= tok_in.active;
      if (tok_in.active && !tok_in.found && hit) begin
        tok_out.found <= 1'b1;
        tok_out.kind  <= entry.kind;
        tok_out.port  <= entry.port;
      end else begin
        tok_out.found <= tok_in.found;
        tok_out.kind  <= tok_in.kind;
        tok_out.port  <= tok_in.port;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/port_rule_packet_filter_top.sv
// top level: port rule packet filter built as a chain of rule cells
//
//  channel | dir | handshake     | contents
//  in_ch   | in  | valid / ready | command, packet header, rule fields
//  out_ch  | out | valid / ready | verdict, rewrite, status, count, read entry
//  cfg     | in  | cfg_we        | proxy address
//
// add and delete update the cell row at acceptance, and the result is presented in the cycle after
// classify and read send a token from tok_q down the row of RULE_DEPTH cells
// one transaction at a time; in_ch.ready is low from acceptance until the result is taken
// rst is synchronous and clears all rules and restores the proxy address
`timescale 1ns / 1ps
`default_nettype none
module port_rule_packet_filter_top
  import prpf_pkg::*;
#(
  parameter int RULE_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  prpf_in_if.sink          in_ch,
  prpf_out_if.source       out_ch
);

  localparam int CW = $clog2(RULE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RULE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_RESULT} state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic [31:0] proxy_address;
  logic [1:0]  cmd_q;
  logic [15:0] sport_q;
  logic [15:0] dport_q;
  logic [31:0] daddr_q;
  query_t      query;
  edit_t       edit;
  tok_t        tok_launch;
  tok_t        tok_q;
  tok_t        toks [RULE_DEPTH+1];
  entry_t      entries [RULE_DEPTH+1];

  logic             accept;
  logic [CNT_W-1:0] count_w;
  logic [CNT_W-1:0] ridx_w;
  logic [31:0]      cnt32_next;
  tok_t             tok_end;

  assign accept  = in_ch.valid && in_ch.ready;
  assign count_w = CNT_W'(count);
  assign ridx_w  = CNT_W'(in_ch.rule_index);
  assign in_ch.ready = (state == S_IDLE);
  assign tok_end = toks[RULE_DEPTH];

  always_comb begin
    edit.add   = accept && in_ch.cmd == CMD_ADD && count_w != DEPTH_C;
    edit.del   = accept && in_ch.cmd == CMD_DELETE && ridx_w < count_w;
    edit.count = count_w;
    edit.idx   = ridx_w;
    edit.kind  = in_ch.rule_kind;
    edit.port  = in_ch.rule_port;
    tok_launch.active = accept && (in_ch.cmd == CMD_CLASSIFY ||
                                   (in_ch.cmd == CMD_READ && ridx_w < count_w));
    tok_launch.found  = 1'b0;
    tok_launch.kind   = '0;
    tok_launch.port   = '0;
  end

  // token enters the row from tok_q in the cycle after acceptance, when the query register holds the query
  assign toks[0] = tok_q;
  assign entries[RULE_DEPTH] = '0;

  for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
    prpf_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .edit     (edit),
      .query    (query),
      .nb_entry (entries[i+1]),
      .entry    (entries[i]),
      .tok_in   (toks[i]),
      .tok_out  (toks[i+1])
    );
  end

  always_comb begin
    cnt32_next = 32'(count);
    if (edit.add) cnt32_next = cnt32_next + 32'd1;
    if (edit.del) cnt32_next = cnt32_next - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      proxy_address <= PROXY_RESET;
      out_ch.valid  <= 1'b0;
      tok_q.active  <= 1'b0;
    end else begin
      tok_q <= tok_launch;
      if (cfg_we) proxy_address <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= in_ch.cmd;
            sport_q <= in_ch.src_port;
            dport_q <= in_ch.dst_port;
            daddr_q <= in_ch.dst_address;
            query   <= '{is_read: in_ch.cmd == CMD_READ, hook: in_ch.hook_point,
                         sport: in_ch.src_port, dport: in_ch.dst_port, idx: ridx_w};
            count   <= cnt32_next[CW-1:0];
            out_ch.drop            <= 1'b0;
            out_ch.rewritten       <= 1'b0;
            out_ch.out_dst_address <= '0;
            out_ch.out_dst_port    <= '0;
            out_ch.read_kind       <= '0;
            out_ch.read_port       <= '0;
            out_ch.count_now       <= cnt32_next[7:0];
            out_ch.status          <= ST_OK;
            if (tok_launch.active) begin
              state <= S_SEARCH;
            end else begin
              if (in_ch.cmd == CMD_ADD && !edit.add) out_ch.status <= ST_FULL;
              if ((in_ch.cmd == CMD_DELETE || in_ch.cmd == CMD_READ) && !(ridx_w < count_w))
                out_ch.status <= ST_RANGE;
              out_ch.valid <= 1'b1;
              state        <= S_RESULT;
            end
          end
        end
        S_SEARCH: begin
          if (tok_end.active) begin
            if (cmd_q == CMD_READ) begin
              out_ch.read_kind <= tok_end.kind;
              out_ch.read_port <= tok_end.port;
            end else if (tok_end.found && tok_end.kind == KIND_PROXY) begin
              out_ch.rewritten       <= 1'b1;
              out_ch.out_dst_address <= proxy_address;
              out_ch.out_dst_port    <= sport_q;
            end else begin
              out_ch.drop            <= tok_end.found;
              out_ch.out_dst_address <= daddr_q;
              out_ch.out_dst_port    <= dport_q;
            end
            out_ch.valid <= 1'b1;
            state        <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= DEPTH_C) else $error("rule count beyond table depth");

  a_token_only_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_end.active |-> state == S_SEARCH) else $error("stray search token");

  a_valid_in_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid == (state == S_RESULT)) else $error("result valid out of step");

  a_count_stable_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(count)) else $error("count changed while busy");

endmodule
`default_nettype wire

FILE: dv/tb_scoreboard.sv
// scoreboard: rule table predictor and result checker for the port rule packet filter
`timescale 1ns / 1ps
package filter_check_pkg;
  import prpf_pkg::*;

  localparam int TABLE_DEPTH = 128;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  hook_point;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] dst_address;
    logic [1:0]  rule_kind;
    logic [15:0] rule_port;
    logic [6:0]  rule_index;
  } request_t;

  typedef struct packed {
    logic        drop;
    logic        rewritten;
    logic [31:0] out_dst_address;
    logic [15:0] out_dst_port;
    logic [1:0]  status;
    logic [7:0]  count_now;
    logic [1:0]  read_kind;
    logic [15:0] read_port;
  } verdict_t;

  class filter_scoreboard;
    logic [1:0]  kinds [TABLE_DEPTH];
    logic [15:0] ports [TABLE_DEPTH];
    int          held;
    logic [31:0] proxy_addr;
    verdict_t    pending [$];
    int          checked;
    int          hits;
    int          rewrites;
    int          fulls;
    int          ranges;

    function void clear();
      held = 0;
      proxy_addr = PROXY_RESET;
      pending.delete();
    endfunction

    function void note_request(request_t rq);
      verdict_t v;
      v = '0;
      case (rq.cmd)
        CMD_CLASSIFY: begin
          v.out_dst_address = rq.dst_address;
          v.out_dst_port = rq.dst_port;
          for (int i = 0; i < held; i++) begin
            if (rq.hook_point == HOOK_IN && ports[i] == rq.src_port &&
                kinds[i] == KIND_IN) begin
              v.drop = 1'b1;
              break;
            end
            if (rq.hook_point == HOOK_IN && ports[i] == rq.src_port &&
                kinds[i] == KIND_PROXY) begin
              v.rewritten = 1'b1;
              v.out_dst_address = proxy_addr;
              v.out_dst_port = rq.src_port;
              break;
            end
            if (rq.hook_point == HOOK_OUT && kinds[i] == KIND_OUT &&
                ports[i] == rq.dst_port) begin
              v.drop = 1'b1;
              break;
            end
            if (rq.hook_point == HOOK_FWD && kinds[i] == KIND_FWD &&
                ports[i] == rq.src_port) begin
              v.drop = 1'b1;
              break;
            end
          end
          if (v.drop || v.rewritten) hits++;
          if (v.rewritten) rewrites++;
        end
        CMD_ADD: begin
          if (held >= TABLE_DEPTH) begin
            v.status = ST_FULL;
            fulls++;
          end else begin
            kinds[held] = rq.rule_kind;
            ports[held] = rq.rule_port;
            held++;
          end
        end
        CMD_DELETE: begin
          if (rq.rule_index >= held) begin
            v.status = ST_RANGE;
            ranges++;
          end else begin
            // later rules move up one place
            for (int i = rq.rule_index; i + 1 < held; i++) begin
              kinds[i] = kinds[i+1];
              ports[i] = ports[i+1];
            end
            held--;
          end
        end
        default: begin
          if (rq.rule_index >= held) begin
            v.status = ST_RANGE;
            ranges++;
          end else begin
            v.read_kind = kinds[rq.rule_index];
            v.read_port = ports[rq.rule_index];
          end
        end
      endcase
      v.count_now = held[7:0];
      pending.push_back(v);
    endfunction

    function void check_result(verdict_t got, output string msg);
      verdict_t w;
      msg = "";
      checked++;
      if (pending.size() == 0) begin
        msg = "result with no transaction outstanding";
        return;
      end
      w = pending.pop_front();
      if (got.drop !== w.drop) msg = {msg, $sformatf(" drop %0d/%0d", got.drop, w.drop)};
      if (got.rewritten !== w.rewritten)
        msg = {msg, $sformatf(" rewritten %0d/%0d", got.rewritten, w.rewritten)};
      if (got.out_dst_address !== w.out_dst_address)
        msg = {msg, $sformatf(" addr %h/%h", got.out_dst_address, w.out_dst_address)};
      if (got.out_dst_port !== w.out_dst_port)
        msg = {msg, $sformatf(" port %h/%h", got.out_dst_port, w.out_dst_port)};
      if (got.status !== w.status)
        msg = {msg, $sformatf(" status %0d/%0d", got.status, w.status)};
      if (got.count_now !== w.count_now)
        msg = {msg, $sformatf(" count %0d/%0d", got.count_now, w.count_now)};
      if (got.read_kind !== w.read_kind)
        msg = {msg, $sformatf(" read_kind %0d/%0d", got.read_kind, w.read_kind)};
      if (got.read_port !== w.read_port)
        msg = {msg, $sformatf(" read_port %h/%h", got.read_port, w.read_port)};
    endfunction
  endclass
endpackage

FILE: dv/tb.sv
// testbench top: drives commands and packets into the filter and checks every verdict
`timescale 1ns / 1ps
module tb;
  import prpf_pkg::*;
  import filter_check_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  int          fails = 0;
  int          sent = 0;
  logic [15:0] port_pool [8] = '{16'd0, 16'hffff, 16'd80, 16'd443, 16'd22, 16'd8080,
                                 16'h8000, 16'd1};

  prpf_in_if  in_ch ();
  prpf_out_if out_ch ();

  port_rule_packet_filter_top #(.RULE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  filter_scoreboard sb = new();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(string msg);
    fails++;
    $display("tb: mismatch at %0t:%s", $realtime, msg);
  endtask

  // receiver stall pattern: phases of always-ready and of random stalls
  int stall_mode = 0;
  always @(posedge clk) begin
    if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom & 1);
      default: out_ch.ready <= (($urandom & 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    verdict_t got;
    string msg;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.drop, out_ch.rewritten, out_ch.out_dst_address, out_ch.out_dst_port,
              out_ch.status, out_ch.count_now, out_ch.read_kind, out_ch.read_port};
      sb.check_result(got, msg);
      if (msg != "") report(msg);
    end
  end

  int burst_left = 0;

  // one transaction; the sender sometimes idles between bursts
  task automatic send(request_t rq);
    // valid of the previous transaction is already low by this edge
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom & 1) repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    {in_ch.cmd, in_ch.hook_point, in_ch.src_port, in_ch.dst_port, in_ch.dst_address,
     in_ch.rule_kind, in_ch.rule_port, in_ch.rule_index} <= rq;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rq);
    sent++;
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_proxy(logic [31:0] a);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.proxy_addr = a;
  endtask

  function automatic logic [15:0] pick_port();
    return ($urandom & 3) ? port_pool[$urandom_range(0, 7)] : 16'($urandom);
  endfunction

  function automatic request_t rand_request(bit table_heavy);
    request_t rq;
    logic [95:0] raw;
    int r;
    raw = {$urandom, $urandom, $urandom};
    rq = raw[$bits(request_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < (table_heavy ? 60 : 25)) rq.cmd = CMD_ADD;
    else if (r < (table_heavy ? 65 : 45)) rq.cmd = CMD_DELETE;
    else if (r < (table_heavy ? 70 : 55)) rq.cmd = CMD_READ;
    else rq.cmd = CMD_CLASSIFY;
    rq.src_port = pick_port();
    rq.dst_port = pick_port();
    rq.rule_port = pick_port();
    rq.hook_point = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    if (sb.held > 0 && ($urandom & 3) != 0) rq.rule_index = 7'($urandom_range(0, sb.held - 1));
    return rq;
  endfunction

  initial begin
    request_t rq;
    string msg;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.hook_point = '0;
    in_ch.src_port = '0;
    in_ch.dst_port = '0;
    in_ch.dst_address = '0;
    in_ch.rule_kind = '0;
    in_ch.rule_port = '0;
    in_ch.rule_index = '0;
    sb.clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, range errors, each kind, first-match order
    rq = '0; rq.cmd = CMD_READ; send(rq);
    rq = '0; rq.cmd = CMD_DELETE; rq.rule_index = 7'h7f; send(rq);
    rq = '0; rq.cmd = CMD_CLASSIFY; rq.dst_address = 32'hffffffff; rq.dst_port = 16'hffff;
    send(rq);
    for (int k = 0; k < 4; k++) begin
      rq = '0; rq.cmd = CMD_ADD; rq.rule_kind = 2'(k); rq.rule_port = 16'hffff; send(rq);
    end
    rq = '0; rq.cmd = CMD_ADD; rq.rule_kind = KIND_PROXY; rq.rule_port = 16'd0; send(rq);
    rq = '0; rq.cmd = CMD_ADD; rq.rule_kind = KIND_IN; rq.rule_port = 16'd0; send(rq);
    for (int h = 0; h < 4; h++) begin
      rq = '0; rq.cmd = CMD_CLASSIFY; rq.hook_point = 2'(h); rq.src_port = 16'hffff;
      rq.dst_port = 16'hffff; rq.dst_address = 32'h0a000001; send(rq);
    end
    rq = '0; rq.cmd = CMD_CLASSIFY; rq.dst_port = 16'h1234; send(rq);
    rq = '0; rq.cmd = CMD_READ; rq.rule_index = 7'd3; send(rq);
    rq = '0; rq.cmd = CMD_READ; rq.rule_index = 7'd6; send(rq);
    rq = '0; rq.cmd = CMD_DELETE; rq.rule_index = 7'd0; send(rq);
    rq = '0; rq.cmd = CMD_DELETE; rq.rule_index = 7'd4; send(rq);
    rq = '0; rq.cmd = CMD_CLASSIFY; rq.hook_point = HOOK_IN; send(rq);

    set_proxy(32'h0);
    rq = '0; rq.cmd = CMD_CLASSIFY; rq.hook_point = HOOK_IN; rq.src_port = 16'hffff;
    send(rq);
    set_proxy(32'hffffffff);

    // fill the table to its limit, then overflow
    while (sb.held < TABLE_DEPTH) send(rand_request(1'b1));
    repeat (3) begin
      rq = rand_request(1'b0); rq.cmd = CMD_ADD; send(rq);
    end
    rq = '0; rq.cmd = CMD_READ; rq.rule_index = 7'h7f; send(rq);
    repeat (40) send(rand_request(1'b0));
    rq = '0; rq.cmd = CMD_DELETE; rq.rule_index = 7'h7f; send(rq);

    while (sent < 650) begin
      if (sent == 350) set_proxy($urandom);
      if (sent == 500) set_proxy(PROXY_RESET);
      send(rand_request(sb.held < 8));
    end

    drain();
    $display("tb: %0d transactions, %0d results checked", sent, sb.checked);
    $display("tb: %0d rule hits (%0d proxy rewrites), %0d full adds, %0d range errors",
             sb.hits, sb.rewrites, sb.fulls, sb.ranges);
    if (fails == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
